/* rtl/ple_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ple_pkg
// Shared sizes, operation and status codes and sequencer states of the
// positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  // Storage size and the widths that follow from it.
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the channel words.
  localparam int FUNC_W = 3;
  localparam int POS_W  = 5;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int OCNT_W = 5;

  // Width used to compare a requested position against the fill count.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND   = 3'd0,
    FN_PREPEND  = 3'd1,
    FN_INSERT   = 3'd2,
    FN_DEL_HEAD = 3'd3,
    FN_DEL_TAIL = 3'd4,
    FN_DEL_IDX  = 3'd5,
    FN_DUMP     = 3'd6
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADIDX = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_WR,
    S_INS_WR,
    S_DN_WR,
    S_DEL_FIN,
    S_DP_WR
  } state_e;

endpackage

`default_nettype wire

/* rtl/ple_chan_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ple_chan_if
// Valid/ready channels of the positional list engine: the command channel
// and the result channel.
// ----------------------------------------------------------------------------

// Command word: operation, position and value.
interface ple_in_if;
  logic                              valid;
  logic                              ready;
  logic [ple_pkg::FUNC_W-1:0]        func;
  logic [ple_pkg::POS_W-1:0]         position;
  logic signed [ple_pkg::VAL_W-1:0]  value;

  modport source (output valid, output func, output position, output value,
                  input ready);
  modport sink   (input valid, input func, input position, input value,
                  output ready);
endinterface

// Result word: element, status, count and last flag.
interface ple_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ple_pkg::VAL_W-1:0]  element;
  logic [ple_pkg::STAT_W-1:0]        status;
  logic [ple_pkg::OCNT_W-1:0]        count;
  logic                              last;

  modport source (output valid, output element, output status, output count,
                  output last, input ready);
  modport sink   (input valid, input element, input status, input count,
                  input last, output ready);
endinterface

`default_nettype wire

/* rtl/ple_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ple_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is issued.
// ----------------------------------------------------------------------------
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire [WIDTH-1:0]          wdata_i,
  input  wire                      re_i,
  input  wire [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/positional_list_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed 32-bit values held in one RAM. Inserts and
// deletes shift the entries behind the position through the RAM; a dump
// reads the entries out in order.
// ----------------------------------------------------------------------------
//  channel  dir  word                               accepted when
//  in_i     in   func, position, value              valid && ready
//  out_o    out  element, status, count, last       valid && ready
//
// A rejected operation, an append, a delete of the tail entry and an empty
// dump answer in the cycle after the command is taken. An insert or delete
// that must move entries shifts them through the RAM before it answers;
// the RAM moves one entry per cycle (one read, one write). A dump emits
// one word per cycle while the result is taken, after a registered read.
// Reset empties the list at once; the RAM itself is not cleared.
// A stalled result holds the engine; a new command is taken while the last
// result is being handed off.
// ----------------------------------------------------------------------------
module positional_list_engine (
  input  wire        clk_i,
  input  wire        rst_ni,
  ple_in_if.sink     in_i,
  ple_out_if.source  out_o
);

  localparam int IDX_W = ple_pkg::IDX_W;
  localparam int CNT_W = ple_pkg::CNT_W;
  localparam int CMP_W = ple_pkg::CMP_W;

  ple_pkg::state_e  state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [ple_pkg::VAL_W-1:0] val_q, val_d;

  // RAM port signals.
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_waddr;
  logic [ple_pkg::VAL_W-1:0] ram_wdata;
  logic                      ram_re;
  logic [IDX_W-1:0]          ram_raddr;
  logic [ple_pkg::VAL_W-1:0] ram_rdata;

  // Output register.
  logic                       out_valid_q;
  logic [ple_pkg::VAL_W-1:0]  element_q;
  ple_pkg::status_e           status_q;
  logic [ple_pkg::OCNT_W-1:0] ocount_q;
  logic                       last_q;

  logic                       out_free;
  logic                       out_load;
  logic [ple_pkg::VAL_W-1:0]  ld_elem;
  ple_pkg::status_e           ld_status;
  logic                       ld_last;

  logic [CMP_W-1:0] cnt_ext, pos_ext, ins_pos, del_pos;
  logic             at_tail;

  ple_ram #(
    .WIDTH (ple_pkg::VAL_W),
    .DEPTH (ple_pkg::CAPACITY)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || out_o.ready;

  // Positions of the operation, widened for comparison with the count.
  assign cnt_ext = CMP_W'(count_q);
  assign pos_ext = CMP_W'(in_i.position);
  assign at_tail = (CNT_W'(ptr_q) == count_q - CNT_W'(1));

  always_comb begin
    case (in_i.func)
      ple_pkg::FN_APPEND:  ins_pos = cnt_ext;
      ple_pkg::FN_PREPEND: ins_pos = '0;
      default:             ins_pos = pos_ext;
    endcase
    case (in_i.func)
      ple_pkg::FN_DEL_HEAD: del_pos = '0;
      ple_pkg::FN_DEL_TAIL: del_pos = cnt_ext - CMP_W'(1);
      default:              del_pos = pos_ext;
    endcase
  end

  // Sequencer: next state, RAM accesses and result loading.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    pos_d     = pos_q;
    val_d     = val_q;
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = ptr_q;
    out_load  = 1'b0;
    ld_elem   = '0;
    ld_status = ple_pkg::ST_OK;
    ld_last   = 1'b1;
    in_i.ready = 1'b0;

    case (state_q)
      ple_pkg::S_IDLE: begin
        in_i.ready = out_free;
        if (in_i.valid && out_free) begin
          val_d = in_i.value;
          case (in_i.func)
            ple_pkg::FN_APPEND, ple_pkg::FN_PREPEND, ple_pkg::FN_INSERT: begin
              pos_d = IDX_W'(ins_pos);
              if (ins_pos > cnt_ext) begin
                out_load  = 1'b1;
                ld_status = ple_pkg::ST_BADIDX;
              end else if (count_q >= CNT_W'(ple_pkg::CAPACITY)) begin
                out_load  = 1'b1;
                ld_status = ple_pkg::ST_FULL;
              end else if (ins_pos == cnt_ext) begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(ins_pos);
                ram_wdata = in_i.value;
                count_d   = count_q + CNT_W'(1);
                out_load  = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = IDX_W'(count_q - CNT_W'(1));
                ptr_d     = IDX_W'(count_q - CNT_W'(1));
                state_d   = ple_pkg::S_UP_WR;
              end
            end
            ple_pkg::FN_DEL_HEAD, ple_pkg::FN_DEL_TAIL, ple_pkg::FN_DEL_IDX: begin
              if (count_q == '0) begin
                out_load  = 1'b1;
                ld_status = ple_pkg::ST_EMPTY;
              end else if (del_pos >= cnt_ext) begin
                out_load  = 1'b1;
                ld_status = ple_pkg::ST_BADIDX;
              end else if (del_pos == cnt_ext - CMP_W'(1)) begin
                count_d  = count_q - CNT_W'(1);
                out_load = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = IDX_W'(del_pos + CMP_W'(1));
                ptr_d     = IDX_W'(del_pos + CMP_W'(1));
                state_d   = ple_pkg::S_DN_WR;
              end
            end
            ple_pkg::FN_DUMP: begin
              if (count_q == '0) begin
                out_load  = 1'b1;
                ld_status = ple_pkg::ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                ptr_d     = '0;
                state_d   = ple_pkg::S_DP_WR;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Move one entry up by one slot; read the next lower entry.
      ple_pkg::S_UP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q + IDX_W'(1);
        if (ptr_q == pos_q) begin
          state_d = ple_pkg::S_INS_WR;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q - IDX_W'(1);
          ptr_d     = ptr_q - IDX_W'(1);
        end
      end

      // Drop the new value into the opened slot once the result can go out.
      ple_pkg::S_INS_WR: begin
        if (out_free) begin
          ram_we    = 1'b1;
          ram_waddr = pos_q;
          ram_wdata = val_q;
          count_d   = count_q + CNT_W'(1);
          out_load  = 1'b1;
          state_d   = ple_pkg::S_IDLE;
        end
      end

      // Move one entry down by one slot; read the next higher entry.
      ple_pkg::S_DN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q - IDX_W'(1);
        if (at_tail) begin
          state_d = ple_pkg::S_DEL_FIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q + IDX_W'(1);
          ptr_d     = ptr_q + IDX_W'(1);
        end
      end

      ple_pkg::S_DEL_FIN: begin
        if (out_free) begin
          count_d  = count_q - CNT_W'(1);
          out_load = 1'b1;
          state_d  = ple_pkg::S_IDLE;
        end
      end

      // Emit the entry just read and fetch the following one.
      ple_pkg::S_DP_WR: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_elem  = ram_rdata;
          ld_last  = at_tail;
          if (at_tail) begin
            state_d = ple_pkg::S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_q + IDX_W'(1);
            ptr_d     = ptr_q + IDX_W'(1);
          end
        end
      end

      default: begin
        state_d = ple_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ple_pkg::S_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    val_q <= val_d;
    if (out_load) begin
      element_q <= ld_elem;
      status_q  <= ld_status;
      ocount_q  <= ple_pkg::OCNT_W'(count_d);
      last_q    <= ld_last;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.element = element_q;
  assign out_o.status  = status_q;
  assign out_o.count   = ocount_q;
  assign out_o.last    = last_q;

  // The fill count never passes the capacity.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(ple_pkg::CAPACITY))
    else $error("list count exceeds capacity");

  // A shift never reads the slot it writes in the same cycle.
  a_no_rw_clash : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("RAM read and write hit the same slot");

  // A result word that leaves with last low must carry ok status.
  a_last_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.last |-> out_o.status == ple_pkg::ST_OK)
    else $error("non-final result without ok status");

  // The dump pointer stays inside the filled part of the list.
  a_dump_ptr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ple_pkg::S_DP_WR |-> CNT_W'(ptr_q) < count_q)
    else $error("dump pointer beyond list end");

  // A delete shift is only under way while the list holds entries.
  a_shift_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ple_pkg::S_DN_WR |-> count_q != '0)
    else $error("delete shift on an empty list");

endmodule

`default_nettype wire

/* bench/tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the positional list engine. A queue-based model of
// the list predicts every result word of each accepted command; a checker
// compares each result word from the block with the oldest prediction. Both
// channels idle at random, with one stretch of full-rate traffic.
// ----------------------------------------------------------------------------
module tb;
  import ple_pkg::*;

  // The one function code the block leaves unused; it must be ignored.
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
  localparam int IDLE_PCT   = 14;
  localparam int RAND_ITEMS = 410;
  localparam int DRAIN_CYC  = 40;
  localparam int MAX_SHOWN  = 10;

  // One result word as the engine should produce it.
  typedef struct packed {
    logic signed [VAL_W-1:0] element;
    status_e                 status;
    logic [OCNT_W-1:0]       count;
    logic                    last;
  } reply_t;

  logic clk;
  logic rst_n;
  bit   calm;
  int   faults;

  // Model of the stored list and the result words still owed by the block.
  logic signed [VAL_W-1:0] list_image[$];
  reply_t                  owed[$];

  ple_in_if  cmd_ch ();
  ple_out_if res_ch ();

  positional_list_engine dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_ch),
    .out_o  (res_ch)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #10_000_000;
    $display("positional_list_engine regression: fail");
    $finish;
  end

  // Decides whether a channel side sits out the current cycle.
  function automatic bit idle_roll();
    return !calm && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  // Records one failure; only the first few are printed.
  function automatic void note_fault(input string msg);
    faults++;
    if (faults <= MAX_SHOWN) begin
      $display("%s", msg);
    end
  endfunction

  function automatic void owe_reply(input logic signed [VAL_W-1:0] elem, input status_e st,
                                    input logic fin);
    reply_t r;
    r.element = elem;
    r.status  = st;
    r.count   = OCNT_W'(list_image.size());
    r.last    = fin;
    owed.push_back(r);
  endfunction

  // Insert into the model; a bad position is reported before a full list.
  function automatic status_e place_value(input int at, input logic signed [VAL_W-1:0] v);
    if (at > list_image.size()) return ST_BADIDX;
    if (list_image.size() >= CAPACITY) return ST_FULL;
    list_image.insert(at, v);
    return ST_OK;
  endfunction

  // Remove from the model; an empty list is reported before a bad position.
  function automatic status_e take_value(input int at);
    if (list_image.size() == 0) return ST_EMPTY;
    if (at >= list_image.size()) return ST_BADIDX;
    list_image.delete(at);
    return ST_OK;
  endfunction

  // Applies one accepted command to the model and queues its result words.
  function automatic void predict_list_op(input logic [FUNC_W-1:0] fn,
                                          input logic [POS_W-1:0] pos,
                                          input logic signed [VAL_W-1:0] val);
    status_e st;
    int      n;
    n = list_image.size();
    case (fn)
      FN_APPEND:   st = place_value(n, val);
      FN_PREPEND:  st = place_value(0, val);
      FN_INSERT:   st = place_value(int'(pos), val);
      FN_DEL_HEAD: st = take_value(0);
      FN_DEL_TAIL: st = (n == 0) ? ST_EMPTY : take_value(n - 1);
      FN_DEL_IDX:  st = take_value(int'(pos));
      FN_DUMP: begin
        // A dump of an empty list still answers with one word.
        if (n == 0) begin
          owe_reply('0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) begin
            owe_reply(list_image[i], ST_OK, i == n - 1);
          end
        end
        return;
      end
      default: return;
    endcase
    owe_reply('0, st, 1'b1);
  endfunction

  // Sends one command word, idling first at random, and predicts it once taken.
  task automatic issue_cmd(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos,
                           input logic signed [VAL_W-1:0] val);
    if (idle_roll()) begin
      cmd_ch.valid <= 1'b0;
      do @(posedge clk); while (idle_roll());
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.func     <= fn;
    cmd_ch.position <= pos;
    cmd_ch.value    <= val;
    do @(posedge clk); while (!cmd_ch.ready);
    predict_list_op(fn, pos, val);
  endtask

  // Result checker and random back-pressure on the result channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if (res_ch.valid && res_ch.ready) begin
        if (owed.size() == 0) begin
          note_fault($sformatf("unexpected result word: element %0d status %0d count %0d last %0b",
                               res_ch.element, res_ch.status, res_ch.count, res_ch.last));
        end else begin
          reply_t want;
          want = owed.pop_front();
          if (res_ch.element !== want.element || res_ch.status !== want.status ||
              res_ch.count !== want.count || res_ch.last !== want.last) begin
            note_fault($sformatf({"result mismatch: expected element %0d status %0d count %0d ",
                                  "last %0b, got element %0d status %0d count %0d last %0b"},
                                 want.element, want.status, want.count, want.last,
                                 res_ch.element, res_ch.status, res_ch.count, res_ch.last));
          end
        end
      end
      res_ch.ready <= !idle_roll();
    end else begin
      res_ch.ready <= 1'b0;
    end
  end

  // Operations on an empty list, an ignored code, and removal of a lone entry.
  task automatic test_empty_list();
    issue_cmd(FN_DEL_HEAD, '0, '0);
    issue_cmd(FN_DEL_TAIL, '0, '0);
    issue_cmd(FN_DEL_IDX, 5'd3, '0);
    issue_cmd(FN_DUMP, '0, '0);
    issue_cmd(FN_INSERT, 5'd1, 32'sd5);
    issue_cmd(FN_UNUSED, 5'd31, -32'sd1);
    issue_cmd(FN_APPEND, '0, 32'sh1234_5678);
    issue_cmd(FN_DEL_IDX, 5'd0, '0);
    issue_cmd(FN_DUMP, '0, '0);
  endtask

  // Fill to capacity, starting with extreme values, then rejected operations on the full list.
  task automatic test_full_list();
    issue_cmd(FN_APPEND, '0, 32'sh7FFF_FFFF);
    issue_cmd(FN_PREPEND, 5'd31, 32'sh8000_0000);
    issue_cmd(FN_INSERT, 5'd1, '0);
    issue_cmd(FN_INSERT, 5'd3, -32'sd1);
    while (list_image.size() < CAPACITY) begin
      issue_cmd(FN_APPEND, '0, $urandom());
    end
    issue_cmd(FN_APPEND, '0, 32'sd1);
    issue_cmd(FN_PREPEND, '0, 32'sd2);
    issue_cmd(FN_INSERT, 5'd16, 32'sd3);
    issue_cmd(FN_INSERT, 5'd17, 32'sd4);
    issue_cmd(FN_DEL_IDX, 5'd16, '0);
    issue_cmd(FN_DUMP, '0, '0);
  endtask

  // Random traffic that drifts between growing and shrinking the list.
  task automatic test_random_traffic();
    int                      taken;
    int                      n;
    int                      r;
    bit                      grow;
    logic [FUNC_W-1:0]       fn;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    taken = 0;
    grow  = 1'b1;
    while (taken < RAND_ITEMS) begin
      if (taken % 40 == 0) grow = ($urandom_range(0, 1) == 1);
      calm = (taken >= 180 && taken < 260);
      n = list_image.size();
      r = $urandom_range(0, 99);
      if (r < 2) begin
        fn = FN_UNUSED;
      end else if (r < 11) begin
        fn = FN_DUMP;
      end else if ($urandom_range(0, 99) < (grow ? 65 : 30)) begin
        case ($urandom_range(0, 2))
          0:       fn = FN_APPEND;
          1:       fn = FN_PREPEND;
          default: fn = FN_INSERT;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0:       fn = FN_DEL_HEAD;
          1:       fn = FN_DEL_TAIL;
          default: fn = FN_DEL_IDX;
        endcase
      end
      // Positions mostly land in the legal range, now and then anywhere.
      if ($urandom_range(0, 7) == 0) begin
        pos = POS_W'($urandom_range(0, 31));
      end else if (fn == FN_DEL_IDX) begin
        pos = POS_W'($urandom_range(0, (n == 0) ? 0 : n - 1));
      end else begin
        pos = POS_W'($urandom_range(0, n));
      end
      case ($urandom_range(0, 15))
        0:       val = 32'sh7FFF_FFFF;
        1:       val = 32'sh8000_0000;
        default: val = $urandom();
      endcase
      issue_cmd(fn, pos, val);
      if (fn != FN_UNUSED) taken++;
    end
    calm = 1'b0;
  endtask

  // Stimulus sequence, drain and verdict.
  initial begin
    faults          = 0;
    calm            = 1'b0;
    rst_n           = 1'b0;
    cmd_ch.valid    = 1'b0;
    cmd_ch.func     = '0;
    cmd_ch.position = '0;
    cmd_ch.value    = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_full_list();
    test_random_traffic();

    // Let the block finish the words still owed, then watch for strays.
    cmd_ch.valid <= 1'b0;
    while (owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    while (owed.size() != 0) begin
      void'(owed.pop_front());
      note_fault("expected result word never arrived");
    end

    if (faults == 0) begin
      $display("positional_list_engine regression: pass");
    end else begin
      $display("positional_list_engine regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
